[rtl/npz_pkg.sv]
`timescale 1ns / 1ps
package npz_pkg;

    localparam int MOM_WIDTH_DEF = 24;
    localparam int unsigned W_MASS_RESET = 80399;

    // operand slice width of the pipelined wide multiplier
    localparam int MUL_PIECE_W = 32;

endpackage

[rtl/npz_delay.sv]
`timescale 1ns / 1ps
module npz_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[rtl/npz_mul.sv]
`timescale 1ns / 1ps
module npz_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [A_W-1:0]     op_a,
    input  logic [B_W-1:0]     op_b,
    output logic [A_W+B_W-1:0] prod
);
    import npz_pkg::*;

    localparam int NA    = (A_W + MUL_PIECE_W - 1) / MUL_PIECE_W;
    localparam int NB    = (B_W + MUL_PIECE_W - 1) / MUL_PIECE_W;
    localparam int PP_W  = 2 * MUL_PIECE_W;
    localparam int SUM_W = (NA + NB) * MUL_PIECE_W;

    logic [NA*MUL_PIECE_W-1:0] a_pad;
    logic [NB*MUL_PIECE_W-1:0] b_pad;
    logic [PP_W-1:0]           pp_next [NA*NB];
    logic [PP_W-1:0]           pp_reg  [NA*NB];
    logic [SUM_W-1:0]          sum_next;
    logic [A_W+B_W-1:0]        prod_reg;

    assign a_pad = (NA*MUL_PIECE_W)'(op_a);
    assign b_pad = (NB*MUL_PIECE_W)'(op_b);

    // slice products, registered in pp_reg
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_next[i*NB+j] = PP_W'(a_pad[i*MUL_PIECE_W +: MUL_PIECE_W])
                                * PP_W'(b_pad[j*MUL_PIECE_W +: MUL_PIECE_W]);
            end
        end
    end

    // shifted sum of the slice products, registered in prod_reg
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum_next = sum_next + (SUM_W'(pp_reg[i*NB+j]) << (MUL_PIECE_W * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA*NB; i++) begin
                pp_reg[i] <= pp_next[i];
            end
            prod_reg <= sum_next[A_W+B_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/npz_sqrt.sv]
`timescale 1ns / 1ps
module npz_sqrt #(
    parameter int D_W = 144
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [D_W-1:0]   rad,
    output logic [D_W/2-1:0] root
);

    localparam int S_W = D_W / 2;
    localparam int R_W = S_W + 2;

    logic [R_W-1:0] rem_reg   [S_W];
    logic [S_W-1:0] root_reg  [S_W];
    logic [D_W-1:0] rad_reg   [S_W];
    logic [R_W-1:0] rem_next  [S_W];
    logic [S_W-1:0] root_next [S_W];
    logic [D_W-1:0] rad_next  [S_W];

    // restoring square root, one result bit per stage
    always_comb begin
        logic [R_W-1:0] rem_in;
        logic [S_W-1:0] root_in;
        logic [D_W-1:0] rad_in;
        logic [R_W-1:0] cur;
        logic [R_W-1:0] trial;
        logic           fits;
        for (int i = 0; i < S_W; i++) begin
            if (i == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = rad;
            end else begin
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
                rad_in  = rad_reg[i-1];
            end
            cur          = {rem_in[R_W-3:0], rad_in[D_W-1 -: 2]};
            trial        = {root_in, 2'b01};
            fits         = (cur >= trial);
            rem_next[i]  = fits ? (cur - trial) : cur;
            root_next[i] = {root_in[S_W-2:0], fits};
            rad_next[i]  = {rad_in[D_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < S_W; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
            end
        end
    end

    assign root = root_reg[S_W-1];

endmodule

[rtl/npz_div.sv]
`timescale 1ns / 1ps
module npz_div #(
    parameter int Q_W  = 24,
    parameter int DV_W = 48
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [DV_W-1:0] rem_init,
    input  logic [Q_W-1:0]  num_low,
    input  logic [DV_W-1:0] divisor,
    output logic [Q_W-1:0]  quot
);

    logic [DV_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]  quot_reg  [Q_W];
    logic [Q_W-1:0]  low_reg   [Q_W];
    logic [DV_W-1:0] dvs_reg   [Q_W];
    logic [DV_W-1:0] rem_next  [Q_W];
    logic [Q_W-1:0]  quot_next [Q_W];
    logic [Q_W-1:0]  low_next  [Q_W];
    logic [DV_W-1:0] dvs_next  [Q_W];

    // restoring division, one quotient bit per stage; rem_init < divisor
    always_comb begin
        logic [DV_W-1:0] rem_in;
        logic [Q_W-1:0]  quot_in;
        logic [Q_W-1:0]  low_in;
        logic [DV_W-1:0] dvs_in;
        logic [DV_W:0]   cur;
        logic [DV_W:0]   diff;
        logic            fits;
        for (int i = 0; i < Q_W; i++) begin
            if (i == 0) begin
                rem_in  = rem_init;
                quot_in = '0;
                low_in  = num_low;
                dvs_in  = divisor;
            end else begin
                rem_in  = rem_reg[i-1];
                quot_in = quot_reg[i-1];
                low_in  = low_reg[i-1];
                dvs_in  = dvs_reg[i-1];
            end
            cur          = {rem_in, low_in[Q_W-1]};
            diff         = cur - {1'b0, dvs_in};
            fits         = (cur >= {1'b0, dvs_in});
            rem_next[i]  = fits ? diff[DV_W-1:0] : cur[DV_W-1:0];
            quot_next[i] = {quot_in[Q_W-2:0], fits};
            low_next[i]  = {low_in[Q_W-2:0], 1'b0};
            dvs_next[i]  = dvs_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < Q_W; i++) begin
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
                low_reg[i]  <= low_next[i];
                dvs_reg[i]  <= dvs_next[i];
            end
        end
    end

    assign quot = quot_reg[Q_W-1];

endmodule

[rtl/neutrino_pz_from_w_mass_top.sv]
`timescale 1ns / 1ps
// Neutrino z momentum from the W mass constraint. Fully pipelined: one item
// per clock unless the pipeline stalls. The pipeline depth is set by the
// bit-per-stage square root (3*MOM_WIDTH stages over a 6*MOM_WIDTH-bit
// discriminant) and the restoring divider (MOM_WIDTH stages). The pipeline
// stalls only when a result waits in the output register and another one is
// ready behind it. w_mass is sampled as items enter, so write it only while
// no item is in flight.
module neutrino_pz_from_w_mass_top #(
    parameter int MOM_WIDTH = npz_pkg::MOM_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic        [MOM_WIDTH-2:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic        [MOM_WIDTH-2:0] s_lep_energy,
    input  logic signed [MOM_WIDTH-1:0] s_lep_px,
    input  logic signed [MOM_WIDTH-1:0] s_lep_py,
    input  logic signed [MOM_WIDTH-1:0] s_lep_pz,
    input  logic        [MOM_WIDTH-2:0] s_lep_mass,
    input  logic signed [MOM_WIDTH-1:0] s_miss_x,
    input  logic signed [MOM_WIDTH-1:0] s_miss_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [MOM_WIDTH-1:0] m_nu_pz,
    output logic                        m_disc_negative,
    output logic                        m_zero_divisor,
    output logic                        m_saturated
);
    import npz_pkg::*;

    localparam int W    = MOM_WIDTH;
    localparam int EW   = W - 1;
    localparam int E2W  = 2 * W - 2;
    localparam int SQW  = 2 * W - 1;
    localparam int PW2  = 2 * W;
    localparam int AW   = 2 * W - 1;
    localparam int TW   = 2 * W;
    localparam int KW   = 2 * W + 1;
    localparam int KMW  = 2 * W;
    localparam int AMW  = 2 * W - 1;
    localparam int KKW  = 2 * KMW;
    localparam int ATW  = AMW + TW;
    localparam int KPW  = KMW + W;
    localparam int XW   = 4 * W + 1;
    localparam int XMW  = 4 * W;
    localparam int DPW  = E2W + XMW;
    localparam int DW   = DPW + 2;
    localparam int SW   = DW / 2;
    localparam int NBW  = 3 * W + 1;
    localparam int NW   = 3 * W + 2;
    localparam int NMW  = 3 * W + 1;
    localparam int DVW  = 2 * W;
    localparam int NV   = 12 + SW + W;
    localparam int SA_W = 3 + E2W + AMW;
    localparam int SB_W = NBW + DVW + 3;

    localparam logic [W-1:0] NU_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NU_MIN = {1'b1, {(W-1){1'b0}}};

    logic          pipe_adv;
    logic [NV-1:0] vld_reg;
    logic [EW-1:0] w_mass_reg;

    // front end registers
    logic        [E2W-1:0] wm2_reg, ms2_reg, e2_s1_reg;
    logic signed [PW2-1:0] pxmx_reg, pymy_reg;
    logic        [SQW-1:0] pz2_reg, mx2_reg, my2_reg;
    logic signed [W-1:0]   pz_s1_reg, pz_s2_reg, pz_s3_reg;
    logic signed [PW2-1:0] pzsq_next, mxsq_next, mysq_next;

    logic signed [AW-1:0]  hdiff_reg;
    logic signed [KW-1:0]  pp_reg;
    logic signed [AW-1:0]  a_s2_reg, a_s3_reg;
    logic        [TW-1:0]  t_s2_reg, t_s3_reg, t_s4_reg;
    logic        [E2W-1:0] e2_s2_reg, e2_s3_reg, e2_s4_reg;
    logic signed [KW-1:0]  k_reg;

    logic [KMW-1:0] kmag_reg;
    logic [AMW-1:0] amag_reg;
    logic [W-1:0]   pzmag_reg;
    logic           aneg_s4_reg, nbneg_s4_reg, zero_s4_reg;

    // after the first multiplier bank
    logic [KKW-1:0]  kk;
    logic [ATW-1:0]  at;
    logic [KPW-1:0]  kpz;
    logic [SA_W-1:0] side_a_out;
    logic            aneg_a, nbneg_a, zero_a;
    logic [E2W-1:0]  e2_a;
    logic [AMW-1:0]  amag_a;

    logic signed [XW-1:0]  x_next;
    logic signed [NBW-1:0] nbpos_next;
    logic        [XMW-1:0] xuse_reg;
    logic                  dneg_s7_reg, aneg_s7_reg, zero_s7_reg;
    logic signed [NBW-1:0] nb_s7_reg;
    logic        [E2W-1:0] e2_s7_reg;
    logic        [DVW-1:0] dmag_s7_reg;

    // discriminant and square root
    logic [DPW-1:0]        dprod;
    logic [SW-1:0]         sroot;
    logic [SB_W-1:0]       side_b_out;
    logic signed [NBW-1:0] nb_b;
    logic [DVW-1:0]        dmag_b;
    logic                  aneg_b, zero_b, dneg_b;

    logic signed [NW-1:0] num_reg;
    logic [DVW-1:0]       dmag_p1_reg, dmag_p2_reg, dmag_p3_reg;
    logic                 aneg_p1_reg, zero_p1_reg, dneg_p1_reg;
    logic [NMW-1:0]       nmag_reg, nmag_p3_reg;
    logic                 qneg_p2_reg, zero_p2_reg, dneg_p2_reg;
    logic                 qneg_p3_reg, zero_p3_reg, dneg_p3_reg, ovf_reg;
    logic                 pick_lo;

    // divider and output
    logic [W-1:0] quot;
    logic [3:0]   side_c_out;
    logic         qneg_c, ovf_c, zero_c, dneg_c;
    logic         sat_next;
    logic [W-1:0] nu_next;

    logic         m_valid_reg;
    logic [W-1:0] m_nu_pz_reg;
    logic         m_disc_negative_reg, m_zero_divisor_reg, m_saturated_reg;

    // only a result that cannot move into a full output register stalls
    assign pipe_adv = !(vld_reg[NV-1] && m_valid_reg && !m_ready);
    assign s_ready  = pipe_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_mass_reg <= EW'(W_MASS_RESET);
        end else if (cfg_wr_en) begin
            w_mass_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_adv) begin
            vld_reg <= {vld_reg[NV-2:0], s_valid};
        end
    end

    assign pzsq_next = PW2'(s_lep_pz) * PW2'(s_lep_pz);
    assign mxsq_next = PW2'(s_miss_x) * PW2'(s_miss_x);
    assign mysq_next = PW2'(s_miss_y) * PW2'(s_miss_y);

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            // squares and cross products
            wm2_reg   <= E2W'(w_mass_reg) * E2W'(w_mass_reg);
            ms2_reg   <= E2W'(s_lep_mass) * E2W'(s_lep_mass);
            e2_s1_reg <= E2W'(s_lep_energy) * E2W'(s_lep_energy);
            pxmx_reg  <= PW2'(s_lep_px) * PW2'(s_miss_x);
            pymy_reg  <= PW2'(s_lep_py) * PW2'(s_miss_y);
            pz2_reg   <= pzsq_next[SQW-1:0];
            mx2_reg   <= mxsq_next[SQW-1:0];
            my2_reg   <= mysq_next[SQW-1:0];
            pz_s1_reg <= s_lep_pz;

            hdiff_reg <= $signed({1'b0, wm2_reg} - {1'b0, ms2_reg});
            pp_reg    <= KW'(pxmx_reg) + KW'(pymy_reg);
            a_s2_reg  <= $signed({1'b0, e2_s1_reg} - pz2_reg);
            t_s2_reg  <= TW'(mx2_reg) + TW'(my2_reg);
            e2_s2_reg <= e2_s1_reg;
            pz_s2_reg <= pz_s1_reg;

            // half of the mass term, rounded toward zero
            k_reg     <= KW'(hdiff_reg >>> 1) + pp_reg
                       + KW'(hdiff_reg[AW-1] & hdiff_reg[0]);
            a_s3_reg  <= a_s2_reg;
            t_s3_reg  <= t_s2_reg;
            e2_s3_reg <= e2_s2_reg;
            pz_s3_reg <= pz_s2_reg;

            kmag_reg     <= k_reg[KW-1] ? KMW'(-k_reg) : KMW'(k_reg);
            amag_reg     <= a_s3_reg[AW-1] ? AMW'(-a_s3_reg) : AMW'(a_s3_reg);
            pzmag_reg    <= pz_s3_reg[W-1] ? W'(-pz_s3_reg) : W'(pz_s3_reg);
            aneg_s4_reg  <= a_s3_reg[AW-1];
            nbneg_s4_reg <= k_reg[KW-1] ^ pz_s3_reg[W-1];
            zero_s4_reg  <= (a_s3_reg == '0);
            t_s4_reg     <= t_s3_reg;
            e2_s4_reg    <= e2_s3_reg;
        end
    end

    npz_mul #(.A_W(KMW), .B_W(KMW)) u_mul_kk (
        .aclk(aclk), .en(pipe_adv), .op_a(kmag_reg), .op_b(kmag_reg), .prod(kk)
    );

    npz_mul #(.A_W(AMW), .B_W(TW)) u_mul_at (
        .aclk(aclk), .en(pipe_adv), .op_a(amag_reg), .op_b(t_s4_reg), .prod(at)
    );

    npz_mul #(.A_W(KMW), .B_W(W)) u_mul_kpz (
        .aclk(aclk), .en(pipe_adv), .op_a(kmag_reg), .op_b(pzmag_reg), .prod(kpz)
    );

    npz_delay #(.WIDTH(SA_W), .DEPTH(2)) u_side_a (
        .aclk(aclk),
        .en  (pipe_adv),
        .din ({aneg_s4_reg, nbneg_s4_reg, zero_s4_reg, e2_s4_reg, amag_reg}),
        .dout(side_a_out)
    );

    assign {aneg_a, nbneg_a, zero_a, e2_a, amag_a} = side_a_out;

    // disc = 4 * E^2 * (k^2 - a*T); X below is the bracket
    assign x_next     = aneg_a ? $signed(XW'(kk) + XW'(at)) : $signed(XW'(kk) - XW'(at));
    assign nbpos_next = $signed(NBW'({kpz, 1'b0}));

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            xuse_reg    <= x_next[XW-1] ? '0 : x_next[XMW-1:0];
            dneg_s7_reg <= x_next[XW-1] & (e2_a != '0);
            nb_s7_reg   <= nbneg_a ? -nbpos_next : nbpos_next;
            e2_s7_reg   <= e2_a;
            dmag_s7_reg <= {amag_a, 1'b0};
            aneg_s7_reg <= aneg_a;
            zero_s7_reg <= zero_a;
        end
    end

    npz_mul #(.A_W(E2W), .B_W(XMW)) u_mul_disc (
        .aclk(aclk), .en(pipe_adv), .op_a(e2_s7_reg), .op_b(xuse_reg), .prod(dprod)
    );

    npz_sqrt #(.D_W(DW)) u_sqrt (
        .aclk(aclk), .en(pipe_adv), .rad({dprod, 2'b00}), .root(sroot)
    );

    npz_delay #(.WIDTH(SB_W), .DEPTH(2 + SW)) u_side_b (
        .aclk(aclk),
        .en  (pipe_adv),
        .din ({nb_s7_reg, dmag_s7_reg, aneg_s7_reg, zero_s7_reg, dneg_s7_reg}),
        .dout(side_b_out)
    );

    assign {nb_b, dmag_b, aneg_b, zero_b, dneg_b} = side_b_out;

    // smaller-magnitude root: the minus root only when -b > 0 and sqrt > 0
    assign pick_lo = !nb_b[NBW-1] && (nb_b != '0) && (sroot != '0);

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            num_reg     <= pick_lo ? $signed(NW'(nb_b) - NW'(sroot))
                                   : $signed(NW'(nb_b) + NW'(sroot));
            dmag_p1_reg <= dmag_b;
            aneg_p1_reg <= aneg_b;
            zero_p1_reg <= zero_b;
            dneg_p1_reg <= dneg_b;

            nmag_reg    <= num_reg[NW-1] ? NMW'(-num_reg) : NMW'(num_reg);
            qneg_p2_reg <= num_reg[NW-1] ^ aneg_p1_reg;
            dmag_p2_reg <= dmag_p1_reg;
            zero_p2_reg <= zero_p1_reg;
            dneg_p2_reg <= dneg_p1_reg;

            // quotient wider than W bits always clips
            ovf_reg     <= (nmag_reg[NMW-1:W] >= (NMW-W)'(dmag_p2_reg));
            nmag_p3_reg <= nmag_reg;
            dmag_p3_reg <= dmag_p2_reg;
            qneg_p3_reg <= qneg_p2_reg;
            zero_p3_reg <= zero_p2_reg;
            dneg_p3_reg <= dneg_p2_reg;
        end
    end

    npz_div #(.Q_W(W), .DV_W(DVW)) u_div (
        .aclk    (aclk),
        .en      (pipe_adv),
        .rem_init(nmag_p3_reg[W +: DVW]),
        .num_low (nmag_p3_reg[W-1:0]),
        .divisor (dmag_p3_reg),
        .quot    (quot)
    );

    npz_delay #(.WIDTH(4), .DEPTH(W)) u_side_c (
        .aclk(aclk),
        .en  (pipe_adv),
        .din ({qneg_p3_reg, ovf_reg, zero_p3_reg, dneg_p3_reg}),
        .dout(side_c_out)
    );

    assign {qneg_c, ovf_c, zero_c, dneg_c} = side_c_out;

    assign sat_next = ovf_c || (qneg_c ? (quot > NU_MIN) : quot[W-1]);

    always_comb begin
        if (sat_next) begin
            nu_next = qneg_c ? NU_MIN : NU_MAX;
        end else begin
            nu_next = qneg_c ? (W'(0) - quot) : quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_adv && vld_reg[NV-1]) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv && vld_reg[NV-1]) begin
            m_nu_pz_reg         <= zero_c ? '0 : nu_next;
            m_disc_negative_reg <= !zero_c && dneg_c;
            m_zero_divisor_reg  <= zero_c;
            m_saturated_reg     <= !zero_c && sat_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nu_pz         = $signed(m_nu_pz_reg);
    assign m_disc_negative = m_disc_negative_reg;
    assign m_zero_divisor  = m_zero_divisor_reg;
    assign m_saturated     = m_saturated_reg;

`ifndef NO_ASSERTIONS
    a_zero_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_zero_divisor_reg |->
            (m_nu_pz_reg == '0) && !m_disc_negative_reg && !m_saturated_reg)
        else $error("zero divisor result carries a value or other flags");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_saturated_reg |-> (m_nu_pz_reg == NU_MAX || m_nu_pz_reg == NU_MIN))
        else $error("saturated result not at a range bound");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_adv |=> vld_reg[NV-1] && m_valid_reg)
        else $error("stalled item lost from pipeline tail or output");
`endif

endmodule

[test/neutrino_pz_from_w_mass_top_tb.sv]
`timescale 1ns / 1ps
module neutrino_pz_from_w_mass_top_tb;

    localparam int MW = npz_pkg::MOM_WIDTH_DEF;
    localparam int PIPE_LAT = 13 + 4 * MW;
    localparam logic signed [MW-1:0] POS_MAX = {1'b0, {(MW-1){1'b1}}};
    localparam logic signed [MW-1:0] NEG_MAX = {1'b1, {(MW-1){1'b0}}};
    localparam logic [MW-2:0] U_MAX = '1;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic        [MW-2:0] energy;
        logic signed [MW-1:0] px;
        logic signed [MW-1:0] py;
        logic signed [MW-1:0] pz;
        logic        [MW-2:0] mass;
        logic signed [MW-1:0] mx;
        logic signed [MW-1:0] my;
    } lepton_t;

    typedef struct {
        logic signed [MW-1:0] nu_pz;
        logic                 disc_neg;
        logic                 zero_div;
        logic                 sat;
    } nu_sol_t;

    typedef struct {
        lepton_t ev;
        bit      known;
        nu_sol_t sol;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic        [MW-2:0] cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic        [MW-2:0] s_lep_energy;
    logic signed [MW-1:0] s_lep_px;
    logic signed [MW-1:0] s_lep_py;
    logic signed [MW-1:0] s_lep_pz;
    logic        [MW-2:0] s_lep_mass;
    logic signed [MW-1:0] s_miss_x;
    logic signed [MW-1:0] s_miss_y;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [MW-1:0] m_nu_pz;
    logic                 m_disc_negative;
    logic                 m_zero_divisor;
    logic                 m_saturated;

    neutrino_pz_from_w_mass_top #(.MOM_WIDTH(MW)) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_lep_energy   (s_lep_energy),
        .s_lep_px       (s_lep_px),
        .s_lep_py       (s_lep_py),
        .s_lep_pz       (s_lep_pz),
        .s_lep_mass     (s_lep_mass),
        .s_miss_x       (s_miss_x),
        .s_miss_y       (s_miss_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_nu_pz        (m_nu_pz),
        .m_disc_negative(m_disc_negative),
        .m_zero_divisor (m_zero_divisor),
        .m_saturated    (m_saturated)
    );

    logic [MW-2:0] w_mass_model;
    nu_sol_t       pending_sols[$];
    int            errors;
    bit            quiet;
    bit            hold_sink;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic wide_t isqrt_floor(wide_t v);
        wide_t root, trial;
        root = '0;
        for (int bitpos = 79; bitpos >= 0; bitpos--) begin
            trial = root | (wide_t'(1) <<< bitpos);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic nu_sol_t solve_nu_pz(lepton_t ev, logic [MW-2:0] wm);
        wide_t e, px, py, pz, ms, mx, my, w, k, a, b, c, disc, s, lo, hi, num, q;
        nu_sol_t r;
        e = ev.energy; ms = ev.mass; w = wm;
        px = ev.px; py = ev.py; pz = ev.pz; mx = ev.mx; my = ev.my;
        r = '{nu_pz: '0, disc_neg: 1'b0, zero_div: 1'b0, sat: 1'b0};
        k = (w * w - ms * ms) / 2 + px * mx + py * my;
        a = e * e - pz * pz;
        if (a == 0) begin
            r.zero_div = 1'b1;
            return r;
        end
        b = -2 * k * pz;
        c = e * e * (mx * mx + my * my) - k * k;
        disc = b * b - 4 * a * c;
        if (disc < 0) begin
            r.disc_neg = 1'b1;
            num = -b;
        end else begin
            s = isqrt_floor(disc);
            lo = -b - s;
            hi = -b + s;
            num = ((lo < 0 ? -lo : lo) < (hi < 0 ? -hi : hi)) ? lo : hi;
        end
        q = num / (2 * a);
        if (q > wide_t'(POS_MAX)) begin
            q = POS_MAX; r.sat = 1'b1;
        end else if (q < wide_t'(NEG_MAX)) begin
            q = NEG_MAX; r.sat = 1'b1;
        end
        r.nu_pz = q[MW-1:0];
        return r;
    endfunction

    // drive one item and hold it until the block takes it
    task automatic send_event(lepton_t ev, bit known, nu_sol_t sol);
        int gap;
        s_valid      <= 1'b1;
        s_lep_energy <= ev.energy;
        s_lep_px     <= ev.px;
        s_lep_py     <= ev.py;
        s_lep_pz     <= ev.pz;
        s_lep_mass   <= ev.mass;
        s_miss_x     <= ev.mx;
        s_miss_y     <= ev.my;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_sols.push_back(known ? sol : solve_nu_pz(ev, w_mass_model));
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_sols.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    task automatic write_w_mass(logic [MW-2:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        w_mass_model = val;
        @(posedge aclk);
    endtask

    function automatic lepton_t random_event();
        lepton_t ev;
        int unsigned p;
        ev = '{energy: (MW-1)'($urandom), px: MW'($urandom), py: MW'($urandom),
               pz: MW'($urandom), mass: (MW-1)'($urandom), mx: MW'($urandom),
               my: MW'($urandom)};
        case ($urandom_range(0, 9))
            0, 1: ; // raw noise over the full field ranges
            2: begin
                // a == 0: energy equals |pz|
                ev.pz = $signed(MW'($urandom_range(0, 8388607)));
                if ($urandom_range(0, 1)) ev.pz = -ev.pz;
                ev.energy = (MW-1)'((ev.pz < 0) ? -ev.pz : ev.pz);
            end
            default: begin
                // collision-like lepton, momenta in the tens of GeV
                p = $urandom_range(0, 200000);
                ev.px = MW'(int'($urandom_range(0, p)) - int'(p / 2));
                ev.py = MW'(int'($urandom_range(0, p)) - int'(p / 2));
                ev.pz = MW'(int'($urandom_range(0, 2 * p)) - int'(p));
                ev.mass = (MW-1)'($urandom_range(0, 2000));
                ev.energy = (MW-1)'((ev.px < 0 ? -ev.px : ev.px)
                                  + (ev.py < 0 ? -ev.py : ev.py)
                                  + (ev.pz < 0 ? -ev.pz : ev.pz)
                                  + $urandom_range(0, 3000));
                ev.mx = MW'(int'($urandom_range(0, 200000)) - 100000);
                ev.my = MW'(int'($urandom_range(0, 200000)) - 100000);
            end
        endcase
        return ev;
    endfunction

    // result sink with random back-pressure and one long hold-off
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        nu_sol_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sols.size() == 0) begin
                $display("%0t: unexpected item nu_pz=%0d", $time, m_nu_pz);
                errors++;
            end else begin
                want = pending_sols.pop_front();
                if (m_nu_pz !== want.nu_pz) begin
                    $display("%0t: nu_pz expected %0d actual %0d", $time, want.nu_pz, m_nu_pz);
                    errors++;
                end
                if (m_disc_negative !== want.disc_neg) begin
                    $display("%0t: disc_negative expected %0b actual %0b",
                             $time, want.disc_neg, m_disc_negative);
                    errors++;
                end
                if (m_zero_divisor !== want.zero_div) begin
                    $display("%0t: zero_divisor expected %0b actual %0b",
                             $time, want.zero_div, m_zero_divisor);
                    errors++;
                end
                if (m_saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, m_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        directed_row_t dir_rows[12];
        nu_sol_t zero_sol, none;
        lepton_t ev;
        int wait_cycles;

        errors = 0;
        quiet = 1'b0;
        hold_sink = 1'b0;
        w_mass_model = (MW-1)'(npz_pkg::W_MASS_RESET);
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_lep_energy = '0;
        s_lep_px = '0;
        s_lep_py = '0;
        s_lep_pz = '0;
        s_lep_mass = '0;
        s_miss_x = '0;
        s_miss_y = '0;

        zero_sol = '{nu_pz: '0, disc_neg: 1'b0, zero_div: 1'b1, sat: 1'b0};
        none = '{nu_pz: '0, disc_neg: 1'b0, zero_div: 1'b0, sat: 1'b0};
        dir_rows[0]  = '{'{0, 0, 0, 0, 0, 0, 0}, 1, zero_sol};
        dir_rows[1]  = '{'{U_MAX, POS_MAX, NEG_MAX, POS_MAX, U_MAX, POS_MAX, NEG_MAX},
                         1, zero_sol};
        dir_rows[2]  = '{'{U_MAX, 0, 0, -POS_MAX, 0, 0, 0}, 1, zero_sol};
        dir_rows[3]  = '{'{U_MAX, 0, 0, 0, 0, 0, 0}, 0, none};
        dir_rows[4]  = '{'{U_MAX, POS_MAX, POS_MAX, 0, U_MAX, NEG_MAX, NEG_MAX}, 0, none};
        dir_rows[5]  = '{'{1, 0, 0, NEG_MAX, 0, POS_MAX, POS_MAX}, 0, none};
        dir_rows[6]  = '{'{1, NEG_MAX, NEG_MAX, POS_MAX, U_MAX, NEG_MAX, POS_MAX}, 0, none};
        dir_rows[7]  = '{'{40000, 20000, -15000, 30000, 106, 25000, 10000}, 0, none};
        dir_rows[8]  = '{'{60000, 30000, 20000, -40000, 0, -35000, -5000}, 0, none};
        dir_rows[9]  = '{'{1, 0, 0, 1, 0, 0, 0}, 0, none};
        dir_rows[10] = '{'{2, 0, 0, 1, 0, 1, 1}, 0, none};
        dir_rows[11] = '{'{U_MAX, 1, -1, -1, 1, -1, 1}, 0, none};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_event(dir_rows[i].ev, dir_rows[i].known, dir_rows[i].sol);
        drain_and_settle();

        // w_mass extremes, then random settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_w_mass('0);
                1: write_w_mass(U_MAX);
                default: write_w_mass((MW-1)'($urandom));
            endcase
            if (phase == 2) hold_sink = 1'b1;
            if (phase == 4) quiet = 1'b1;
            for (int n = 0; n < 100; n++) begin
                ev = random_event();
                send_event(ev, 1'b0, none);
            end
            drain_and_settle();
        end

        wait_cycles = 0;
        while (pending_sols.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (errors == 0 && pending_sols.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/npz_pkg.sv
rtl/npz_delay.sv
rtl/npz_mul.sv
rtl/npz_sqrt.sv
rtl/npz_div.sv
rtl/neutrino_pz_from_w_mass_top.sv
test/neutrino_pz_from_w_mass_top_tb.sv
